@@ rtl/core/wdls_pkg.sv @@
// ----------------------------------------------------------------------------
// wdls_pkg
// Shared types and constants of the weighted distance/load selector.
// ----------------------------------------------------------------------------
`default_nettype none

package wdls_pkg;

  localparam int STATUS_W   = 2;
  localparam int DIST_W     = 16;
  localparam int LOAD_W     = 10;
  localparam int BEST_IDX_W = 6;
  localparam int PROD_W     = DIST_W + LOAD_W;
  localparam int SCORE_W    = PROD_W + 1;

  localparam logic [STATUS_W-1:0] ST_UNREACHABLE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DOWN        = 2'd2;

  typedef struct packed {
    logic              elig;
    logic [LOAD_W-1:0] load;
    logic [DIST_W-1:0] distance;
  } entry_t;

  typedef struct packed {
    logic start;
    logic rd;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rd_end;
    logic pipe_empty;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/wdls_ctrl.sv @@
// ----------------------------------------------------------------------------
// wdls_ctrl
// Sequencer: load phase, scan of the stored candidates, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module wdls_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_last,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  output wdls_pkg::ctrl_cmd_t  cmd,
  input  wdls_pkg::dp_stat_t   stat
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       in_fire;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_last) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (stat.rd_end) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat.pipe_empty && out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wdls_dp.sv @@
// ----------------------------------------------------------------------------
// wdls_dp
// Candidate store, eligible maxima, scoring pipeline and best tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module wdls_dp #(
  parameter int MAX_CANDIDATES = 64
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_fire,
  input  wire  [wdls_pkg::STATUS_W-1:0]         in_status,
  input  wire  [wdls_pkg::DIST_W-1:0]           in_distance,
  input  wire  [wdls_pkg::LOAD_W-1:0]           in_cpu_load,
  input  wire  [wdls_pkg::LOAD_W-1:0]           in_load_watermark,
  input  wdls_pkg::ctrl_cmd_t                   cmd,
  output wdls_pkg::dp_stat_t                    stat,
  output logic                                  out_found,
  output logic [wdls_pkg::BEST_IDX_W-1:0]       out_best_index
);

  localparam int IDX_W = $clog2(MAX_CANDIDATES);
  localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

  wdls_pkg::entry_t store_r [MAX_CANDIDATES];

  logic [CNT_W-1:0]                  count_r;
  logic [wdls_pkg::DIST_W-1:0]       max_dist_r;
  logic [wdls_pkg::LOAD_W-1:0]       max_load_r;
  logic [CNT_W-1:0]                  rd_idx_r;

  logic                              s1_v_r;
  logic [CNT_W-1:0]                  s1_idx_r;
  wdls_pkg::entry_t                  s1_q_r;

  logic                              s2_v_r;
  logic                              s2_elig_r;
  logic [CNT_W-1:0]                  s2_idx_r;
  logic [wdls_pkg::PROD_W-1:0]       s2_pd_r;
  logic [wdls_pkg::PROD_W-1:0]       s2_pl_r;

  logic                              have_r;
  logic [CNT_W-1:0]                  best_idx_r;
  logic [wdls_pkg::SCORE_W-1:0]      best_score_r;

  logic                              out_found_r;
  logic [wdls_pkg::BEST_IDX_W-1:0]   out_best_index_r;

  wdls_pkg::entry_t                  wr_entry;
  logic                              room;
  logic                              wr_en;
  logic [wdls_pkg::DIST_W-1:0]       dmax_eff;
  logic [wdls_pkg::LOAD_W-1:0]       lmax_eff;
  logic [wdls_pkg::SCORE_W-1:0]      s2_score;
  logic                              take;

  assign room  = (count_r < CNT_W'(MAX_CANDIDATES));
  assign wr_en = in_fire && room;

  assign wr_entry.distance = in_distance;
  assign wr_entry.load     = in_cpu_load;
  assign wr_entry.elig     = (in_status != wdls_pkg::ST_UNREACHABLE) &&
                             (in_status != wdls_pkg::ST_DOWN) &&
                             (in_cpu_load <= in_load_watermark);

  // a zero maximum acts as one; with zero distances this leaves the load term alone
  assign dmax_eff = (max_dist_r == '0) ? wdls_pkg::DIST_W'(1) : max_dist_r;
  assign lmax_eff = (max_load_r == '0) ? wdls_pkg::LOAD_W'(1) : max_load_r;

  assign s2_score = {1'b0, s2_pd_r} + {1'b0, s2_pl_r};
  assign take     = s2_v_r && s2_elig_r && (!have_r || (s2_score < best_score_r));

  assign stat.rd_end     = (rd_idx_r == (count_r - CNT_W'(1)));
  assign stat.pipe_empty = !s1_v_r && !s2_v_r;

  assign out_found      = out_found_r;
  assign out_best_index = out_best_index_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[count_r[IDX_W-1:0]] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      s1_q_r <= store_r[rd_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      max_dist_r <= '0;
      max_load_r <= '0;
    end else if (cmd.emit) begin
      count_r    <= '0;
      max_dist_r <= '0;
      max_load_r <= '0;
    end else if (wr_en) begin
      count_r <= count_r + CNT_W'(1);
      if (wr_entry.elig && (in_distance > max_dist_r)) begin
        max_dist_r <= in_distance;
      end
      if (wr_entry.elig && (in_cpu_load > max_load_r)) begin
        max_load_r <= in_cpu_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      have_r   <= 1'b0;
    end else begin
      s1_v_r <= cmd.rd;
      s2_v_r <= s1_v_r;
      if (cmd.start) begin
        rd_idx_r <= '0;
        have_r   <= 1'b0;
      end else begin
        if (cmd.rd) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
        if (take) begin
          have_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      s1_idx_r <= rd_idx_r;
    end
    s2_elig_r <= s1_q_r.elig;
    s2_idx_r  <= s1_idx_r;
    s2_pd_r   <= wdls_pkg::PROD_W'(s1_q_r.distance) * wdls_pkg::PROD_W'(lmax_eff);
    s2_pl_r   <= wdls_pkg::PROD_W'(s1_q_r.load) * wdls_pkg::PROD_W'(dmax_eff);
    if (take) begin
      best_idx_r   <= s2_idx_r;
      best_score_r <= s2_score;
    end
    if (cmd.emit) begin
      out_found_r      <= have_r;
      out_best_index_r <= have_r ? wdls_pkg::BEST_IDX_W'(best_idx_r) : '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/weighted_distance_load_selector.sv @@
// ----------------------------------------------------------------------------
// weighted_distance_load_selector
// Picks the eligible server with the least normalized distance-plus-load score.
// ----------------------------------------------------------------------------
// Candidates transfer in one per cycle while in_stall is low and are written
// into an internal store while the eligible distance and load maxima are
// tracked. The transfer that carries in_last starts a scan: the store is read
// once per stored candidate through a read, multiply and compare pipeline, so
// in_stall stays high after the last transfer of a set until its result is
// emitted. The result waits in an output register, and the next set loads
// while it waits. Candidates beyond MAX_CANDIDATES in one set are dropped
// from the choice; in_last still ends the set.
`default_nettype none

module weighted_distance_load_selector #(
  parameter int MAX_CANDIDATES = 64
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [wdls_pkg::STATUS_W-1:0]      in_status,
  input  wire  [wdls_pkg::DIST_W-1:0]        in_distance,
  input  wire  [wdls_pkg::LOAD_W-1:0]        in_cpu_load,
  input  wire  [wdls_pkg::LOAD_W-1:0]        in_load_watermark,
  input  wire                                in_last,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               out_found,
  output logic [wdls_pkg::BEST_IDX_W-1:0]    out_best_index
);

  wdls_pkg::ctrl_cmd_t cmd;
  wdls_pkg::dp_stat_t  stat;
  logic                in_fire;

  assign in_fire = in_valid && !in_stall;

  wdls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  wdls_dp #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_fire           (in_fire),
    .in_status         (in_status),
    .in_distance       (in_distance),
    .in_cpu_load       (in_cpu_load),
    .in_load_watermark (in_load_watermark),
    .cmd               (cmd),
    .stat              (stat),
    .out_found         (out_found),
    .out_best_index    (out_best_index)
  );

endmodule

`default_nettype wire

@@ rtl/core/wdls_checker.sv @@
// ----------------------------------------------------------------------------
// wdls_checker
// Port-level checks of the selector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wdls_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_valid,
  input wire                             in_stall,
  input wire                             in_last,
  input wire                             out_valid,
  input wire                             out_stall,
  input wire                             out_found,
  input wire [wdls_pkg::BEST_IDX_W-1:0]  out_best_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) && $stable(out_best_index))
    else $error("result changed while stalled");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_best_index == '0)
    else $error("nonzero index with nothing found");

  a_last_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input taken during scan");

  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a scan");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear the handshake");

endmodule

bind weighted_distance_load_selector wdls_checker u_wdls_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_last        (in_last),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_found      (out_found),
  .out_best_index (out_best_index)
);

`default_nettype wire
